@@ hdl/lts_pkg.sv @@
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, constants and helpers of the lottery task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package lts_pkg;

  // table geometry
  localparam int NUM_ENTRIES = 64;
  localparam int TICKET_BITS = 8;
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_ENTRIES);

  // fixed field widths of the words
  localparam int IDX_W    = 6;
  localparam int CPU_W    = 3;
  localparam int STAT_W   = 2;
  localparam int TKIN_W   = 8;
  localparam int TOTOUT_W = 14;

  // ticket arithmetic
  localparam int TOTAL_W = $clog2(NUM_ENTRIES * ((1 << TICKET_BITS) - 1) + 1);
  localparam int DVS_W   = TOTAL_W + 1;
  localparam int LFSR_W  = 16;
  localparam int DVD_W   = LFSR_W + 1;
  localparam logic [DVD_W-1:0] DRAW_RANGE = DVD_W'(1 << LFSR_W);
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam int PROD_W  = TICKET_BITS + DVD_W;
  localparam int ACC_W   = PROD_W + 1;

  // item kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_SCHED = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    TS_FREE,
    TS_RUNNABLE,
    TS_RUNNING,
    TS_BLOCKED
  } task_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN1,
    ST_DIV,
    ST_MUL,
    ST_DRAW,
    ST_SCAN2,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              mode;
    logic [IDX_W-1:0]  entry_index;
    logic [STAT_W-1:0] entry_status;
    logic [CPU_W-1:0]  entry_cpu;
    logic [TKIN_W-1:0] entry_tickets;
    logic [CPU_W-1:0]  this_cpu;
    logic              current_valid;
    logic [IDX_W-1:0]  current_index;
  } req_word_t;

  typedef struct packed {
    logic                chosen_valid;
    logic [IDX_W-1:0]    chosen_index;
    logic [TOTOUT_W-1:0] ticket_total;
  } rsp_word_t;

  typedef struct packed {
    task_status_t           status;
    logic [CPU_W-1:0]       cpu;
    logic [TICKET_BITS-1:0] tickets;
  } entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } tbl_req_t;

  // one step of the fibonacci lfsr, taps 0, 2, 3, 5 into the top bit
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

endpackage

`default_nettype wire

@@ hdl/lts_table.sv @@
// ----------------------------------------------------------------------------
// lts_table
// Task entry memory, one write and one registered read per cycle; entries
// never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_table (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lts_pkg::tbl_req_t req,
  output lts_pkg::entry_t        rd_data
);
  import lts_pkg::*;

  entry_t                 mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] written;
  entry_t                 rd_raw;
  logic                   rd_ok;

  // storage array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_raw <= mem[req.rd_addr];
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_ok <= written[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_raw : '0;

endmodule

`default_nettype wire

@@ hdl/lts_div.sv @@
// ----------------------------------------------------------------------------
// lts_div
// Restoring serial divider: draw range over (total + 1), one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [lts_pkg::DVS_W-1:0]  divisor,
  output logic                            done,
  output logic [lts_pkg::DVD_W-1:0]       quotient
);
  import lts_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  // trial subtract
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= STEP_W'(DVD_W);
      done  <= 1'b0;
    end else begin
      done <= (steps == STEP_W'(1));
      if (steps != '0) begin
        steps <= steps - STEP_W'(1);
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= DRAW_RANGE;
      rem <= '0;
      dvs <= divisor;
    end else if (steps != '0) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire

@@ hdl/lottery_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// lottery_task_scheduler
// Task table with lottery selection per asking cpu.
// ----------------------------------------------------------------------------
// write word: result registered after the ST_WRITE and ST_RESP states; next word taken back in idle
// schedule word: result after one scan of the entry memory at a zero total, else its wait is
//   set by any redraws, by two scans of the entry memory (one read per entry each), the
//   17-bit serial divider and the winner's position
// a held-off result adds its wait; one word at a time
// reset: table reads as all free, lfsr back to its seed; takes effect at once
// ----------------------------------------------------------------------------
`default_nettype none

module lottery_task_scheduler (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire lts_pkg::req_word_t req,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output lts_pkg::rsp_word_t      rsp
);
  import lts_pkg::*;

  state_t                 state;
  state_t                 state_next;
  req_word_t              req_q;
  tbl_req_t               tbl_req;
  entry_t                 tbl_rd;

  logic [CNT_W-1:0]       cnt;
  logic                   issue;
  logic                   rd_vld;
  logic [ADDR_W-1:0]      rd_idx;
  logic                   elig;
  logic                   p_vld;
  logic                   p_elig;
  logic [ADDR_W-1:0]      p_idx;
  logic [PROD_W-1:0]      prod;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W-1:0]       acc_sum;

  logic [TOTAL_W-1:0]     total;
  task_status_t           cur_status;
  logic [CPU_W-1:0]       cur_cpu;
  logic                   cur_ok;
  logic                   scan1_done;
  logic                   scan2_end;

  logic                   div_start;
  logic                   div_done;
  logic [DVD_W-1:0]       quotient;
  logic [DVD_W-1:0]       divisor;
  logic [DVD_W-1:0]       limit;
  logic [LFSR_W-1:0]      lfsr;
  logic [LFSR_W-1:0]      lfsr_nx;
  logic                   draw_ok;

  logic                   found;
  logic                   res_chosen;
  logic [ADDR_W-1:0]      res_index;
  logic                   load_rsp;

  // scan helpers
  always_comb begin
    issue      = ((state == ST_SCAN1) || (state == ST_SCAN2)) && (cnt != LAST_CNT);
    elig       = (tbl_rd.status == TS_RUNNABLE) ||
                 ((tbl_rd.status == TS_RUNNING) && (tbl_rd.cpu == req_q.this_cpu));
    scan1_done = (cnt == LAST_CNT) && !rd_vld;
    scan2_end  = found || ((cnt == LAST_CNT) && !rd_vld && !p_vld);
    acc_sum    = acc + ACC_W'(prod);
    lfsr_nx    = lfsr_step(lfsr);
    draw_ok    = {1'b0, lfsr_nx} < limit;
    cur_ok     = req_q.current_valid &&
                 (32'(req_q.current_index) < NUM_ENTRIES) &&
                 (cur_status == TS_RUNNING) && (cur_cpu == req_q.this_cpu);
    load_rsp   = (state == ST_RESP) && (!rsp_valid || rsp_ready);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.mode == MODE_WRITE) ? ST_WRITE : ST_SCAN1;
        end
      end
      ST_WRITE: state_next = ST_RESP;
      ST_SCAN1: begin
        if (scan1_done) begin
          state_next = (total == '0) ? ST_RESP : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_DRAW;
      ST_DRAW: begin
        if (draw_ok) begin
          state_next = ST_SCAN2;
        end
      end
      ST_SCAN2: begin
        if (scan2_end) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (load_rsp) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready       = (state == ST_IDLE);
    div_start       = (state == ST_SCAN1) && scan1_done && (total != '0);
    tbl_req.wr_en   = (state == ST_WRITE) && (32'(req_q.entry_index) < NUM_ENTRIES);
    tbl_req.wr_addr = ADDR_W'(req_q.entry_index);
    tbl_req.wr_data = '{status:  task_status_t'(req_q.entry_status),
                        cpu:     req_q.entry_cpu,
                        tickets: req_q.entry_tickets[TICKET_BITS-1:0]};
    tbl_req.rd_en   = issue;
    tbl_req.rd_addr = cnt[ADDR_W-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_vld <= 1'b0;
      p_vld  <= 1'b0;
      cnt    <= '0;
      found  <= 1'b0;
      lfsr   <= LFSR_SEED;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      p_vld  <= rd_vld && (state == ST_SCAN2);
      if ((state == ST_IDLE) || ((state == ST_DRAW) && draw_ok)) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (state == ST_IDLE) begin
        found <= 1'b0;
      end else if ((state == ST_SCAN2) && p_vld && p_elig && !found &&
                   (acc_sum > ACC_W'(lfsr))) begin
        found <= 1'b1;
      end
      if (state == ST_DRAW) begin
        lfsr <= lfsr_nx;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_idx <= cnt[ADDR_W-1:0];
    p_elig <= elig;
    p_idx  <= rd_idx;
    prod   <= PROD_W'(tbl_rd.tickets) * PROD_W'(divisor);

    if ((state == ST_IDLE) && req_valid) begin
      req_q      <= req;
      total      <= '0;
      cur_status <= TS_FREE;
      cur_cpu    <= '0;
      res_chosen <= 1'b0;
      res_index  <= '0;
    end

    // first scan: eligible ticket total and the current task's entry
    if ((state == ST_SCAN1) && rd_vld) begin
      if (elig) begin
        total <= total + TOTAL_W'(tbl_rd.tickets);
      end
      if (32'(rd_idx) == 32'(req_q.current_index)) begin
        cur_status <= tbl_rd.status;
        cur_cpu    <= tbl_rd.cpu;
      end
    end
    if ((state == ST_SCAN1) && scan1_done && (total == '0)) begin
      res_chosen <= cur_ok;
      res_index  <= cur_ok ? ADDR_W'(req_q.current_index) : '0;
    end

    // scale factor and acceptance limit
    if ((state == ST_DIV) && div_done) begin
      divisor <= (quotient == '0) ? DVD_W'(1) : quotient;
    end
    if (state == ST_MUL) begin
      limit <= DVD_W'(total * divisor);
    end

    // second scan: scaled running sum against the accepted draw
    if ((state == ST_DRAW) && draw_ok) begin
      acc <= '0;
    end else if ((state == ST_SCAN2) && p_vld && p_elig && !found) begin
      acc <= acc_sum;
      if (acc_sum > ACC_W'(lfsr)) begin
        res_chosen <= 1'b1;
        res_index  <= p_idx;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.chosen_valid <= res_chosen;
      rsp.chosen_index <= IDX_W'(res_index);
      rsp.ticket_total <= TOTOUT_W'(total);
    end
  end

  lts_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (tbl_req),
    .rd_data (tbl_rd)
  );

  lts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (DVS_W'(total) + DVS_W'(1)),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

`default_nettype wire
